FILE: rtl/core/per_slot_message_rate_limiter_defines.svh
// ----------------------------------------------------------------------------
// rate limiter assertion macros
// shared property shapes for the checker, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef PER_SLOT_MESSAGE_RATE_LIMITER_DEFINES_SVH
`define PER_SLOT_MESSAGE_RATE_LIMITER_DEFINES_SVH

// same-cycle implication
`define PSMRL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rate limiter check failed");

// next-cycle implication
`define PSMRL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rate limiter check failed");

`endif

FILE: rtl/core/psmrl_pkg.sv
// ----------------------------------------------------------------------------
// psmrl_pkg
// types, codes and constants shared by the rate limiter files
// ----------------------------------------------------------------------------
package psmrl_pkg;

  localparam int SLOTS_DEF        = 64;
  localparam int WINDOW_DEPTH_DEF = 30;

  localparam int TIME_W = 32;
  localparam logic [TIME_W-1:0] WINDOW_SECONDS = 32'd60;

  // reset values of the configuration registers
  localparam logic [4:0] MAX_PER_MIN_RST = 5'd8;
  localparam logic [6:0] BYPASS_RST      = 7'd50;
  localparam logic [5:0] MIN_DELAY_RST   = 6'd4;
  localparam logic       RENEW_RST       = 1'b0;

  typedef enum logic [1:0] {
    CFG_MAX_PER_MIN = 2'd0,
    CFG_BYPASS      = 2'd1,
    CFG_MIN_DELAY   = 2'd2,
    CFG_RENEW       = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [4:0] max_per_minute;
    logic [6:0] bypass_level;
    logic [5:0] min_delay;
    logic       renew_delay;
  } cfg_t;

  typedef enum logic [2:0] {
    V_ACCEPT = 3'd0,
    V_PRIOR  = 3'd1,
    V_NOMSG  = 3'd2,
    V_BYPASS = 3'd3,
    V_SOON   = 3'd4,
    V_RATE   = 3'd5
  } verdict_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LAST,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DECIDE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic lt_min;
    logic gt_window;
  } age_flags_t;

endpackage

FILE: rtl/core/per_slot_message_rate_limiter.sv
// ----------------------------------------------------------------------------
// per_slot_message_rate_limiter
// per-slot chat admission with a sixty-second sliding window
// requests arrive on the in_ stream, one verdict per request leaves on out_;
// registers max_per_minute, bypass_level, min_delay, renew_delay via cfg_
// after reset a clearing pass over all SLOTS slots (64 by default) zeroes the
// per-slot last-accept times and window head/count; in_tready stays low then,
// cfg writes are taken throughout
// one request at a time: early refusals and bypass go straight to the output
// stage, a too-early request after the last-accept check; otherwise the
// sequencer checks the last-accept time, then walks the window, dropping
// expired entries and stopping at the end or at an entry still inside the
// window, then decides; the single age subtractor serves both checks and
// walks the window ram one entry at a time (read, then compare)
// results sit in an output register; once a verdict is loaded the next request
// is taken at once, and a stalled receiver holds that one in its final state
// ----------------------------------------------------------------------------
module per_slot_message_rate_limiter
  import psmrl_pkg::*;
#(
  parameter int SLOTS        = SLOTS_DEF,
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: slot[5:0], now_seconds[37:6], privilege[44:38],
  //           show_request[45], has_message[46], zero pad[47]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,
  // out_tdata: show[0], verdict[3:1], zero pad[7:4]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int SLOT_AW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PTR_W    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W    = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W    = CNT_W + 1;
  localparam int HC_W     = PTR_W + CNT_W;
  localparam int WIN_ALL  = SLOTS * WINDOW_DEPTH;
  localparam int WIN_AW   = (WIN_ALL > 1) ? $clog2(WIN_ALL) : 1;

  // input fields
  logic [5:0]        in_slot;
  logic [TIME_W-1:0] in_now;
  logic [6:0]        in_priv;
  logic              in_show_req;
  logic              in_has_msg;

  assign in_slot     = in_tdata[5:0];
  assign in_now      = in_tdata[37:6];
  assign in_priv     = in_tdata[44:38];
  assign in_show_req = in_tdata[45];
  assign in_has_msg  = in_tdata[46];

  cfg_t cfg;

  psmrl_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer state and working registers
  state_t              state_r, state_nxt;
  logic [SLOT_AW-1:0]  clr_r, clr_nxt;
  logic [SLOT_AW-1:0]  slot_r, slot_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic [WIN_AW-1:0]   base_r, base_nxt;
  logic [PTR_W-1:0]    ptr_r, ptr_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    drop_r, drop_nxt;
  verdict_t            verdict_r, verdict_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  verdict_t            out_verdict_r, out_verdict_nxt;
  logic                out_show_r, out_show_nxt;

  // ram ports
  logic                last_we;
  logic [SLOT_AW-1:0]  last_waddr;
  logic [TIME_W-1:0]   last_wdata;
  logic [TIME_W-1:0]   last_rdata;
  logic                hc_we;
  logic [SLOT_AW-1:0]  hc_waddr;
  logic [HC_W-1:0]     hc_wdata;
  logic [HC_W-1:0]     hc_rdata;
  logic [SLOT_AW-1:0]  slot_raddr;
  logic                win_we;
  logic [WIN_AW-1:0]   win_waddr;
  logic [WIN_AW-1:0]   win_raddr;
  logic [TIME_W-1:0]   win_rdata;

  // misc datapath
  logic                in_acc;
  logic                out_free;
  logic [SLOT_AW-1:0]  in_slot_idx;
  logic                early_hit;
  verdict_t            early_verdict;
  logic [TIME_W-1:0]   stamp;
  age_flags_t          age;
  logic                too_soon;
  logic [PTR_W-1:0]    hc_head;
  logic [CNT_W-1:0]    hc_count;
  logic [CNT_W-1:0]    remain;
  logic [CNT_W-1:0]    limit;
  logic                room;
  logic [PTR_W-1:0]    ptr_inc;
  logic [SUM_W-1:0]    tail_sum;
  logic [SUM_W-1:0]    tail_wrap;
  logic [PTR_W-1:0]    tail_ptr;

  assign in_tready   = (state_r == S_IDLE);
  assign in_acc      = in_tvalid && in_tready;
  assign out_free    = !out_tvalid_r || out_tready;
  assign in_slot_idx = SLOT_AW'(in_slot);

  // checks that need no stored state, in priority order
  always_comb begin
    early_hit     = 1'b1;
    early_verdict = V_PRIOR;
    if (!in_show_req) begin
      early_verdict = V_PRIOR;
    end else if (!in_has_msg) begin
      early_verdict = V_NOMSG;
    end else if ((cfg.bypass_level != '0) && (in_priv >= cfg.bypass_level)) begin
      early_verdict = V_BYPASS;
    end else if (in_slot >= SLOTS) begin
      // slot beyond the store: refused as rate exceeded, nothing touched
      early_verdict = V_RATE;
    end else begin
      early_hit = 1'b0;
    end
  end

  // shared age unit: last-accept time first, then window entries
  assign stamp = (state_r == S_SCAN_CHK) ? win_rdata : last_rdata;

  psmrl_age_unit u_age (
    .now       (now_r),
    .stamp     (stamp),
    .min_delay (cfg.min_delay),
    .flags     (age)
  );

  assign too_soon = (cfg.min_delay != '0) && age.lt_min;

  // window bookkeeping: circular buffer per slot, head pointer and count
  assign hc_head  = hc_rdata[HC_W-1:CNT_W];
  assign hc_count = hc_rdata[CNT_W-1:0];
  assign remain   = cnt_r - drop_r;

  always_comb begin
    if (cfg.max_per_minute > WINDOW_DEPTH) begin
      limit = CNT_W'(WINDOW_DEPTH);
    end else begin
      limit = CNT_W'(cfg.max_per_minute);
    end
  end

  assign room    = remain < limit;
  assign ptr_inc = (ptr_r == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_r + 1'b1;

  // new entry goes after the surviving ones, wrapping once at most
  assign tail_sum  = SUM_W'(remain) + SUM_W'(ptr_r);
  assign tail_wrap = (tail_sum >= SUM_W'(WINDOW_DEPTH)) ?
                     tail_sum - SUM_W'(WINDOW_DEPTH) : tail_sum;
  assign tail_ptr  = PTR_W'(tail_wrap);

  assign slot_raddr = (state_r == S_IDLE) ? in_slot_idx : slot_r;
  assign win_raddr  = base_r + WIN_AW'(ptr_r);
  assign win_waddr  = base_r + WIN_AW'(tail_ptr);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_r == SLOT_AW'(SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = early_hit ? S_DONE : S_LAST;
        end
      end
      S_LAST: begin
        state_nxt = too_soon ? S_DONE : S_SCAN_RD;
      end
      S_SCAN_RD: begin
        state_nxt = (drop_r < cnt_r) ? S_SCAN_CHK : S_DECIDE;
      end
      S_SCAN_CHK: begin
        state_nxt = age.gt_window ? S_SCAN_RD : S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // datapath and ram control
  always_comb begin
    clr_nxt         = clr_r;
    slot_nxt        = slot_r;
    now_nxt         = now_r;
    base_nxt        = base_r;
    ptr_nxt         = ptr_r;
    cnt_nxt         = cnt_r;
    drop_nxt        = drop_r;
    verdict_nxt     = verdict_r;
    out_tvalid_nxt  = out_tvalid_r && !out_tready;
    out_verdict_nxt = out_verdict_r;
    out_show_nxt    = out_show_r;
    last_we         = 1'b0;
    last_waddr      = slot_r;
    last_wdata      = now_r;
    hc_we           = 1'b0;
    hc_waddr        = slot_r;
    hc_wdata        = {ptr_r, remain};
    win_we          = 1'b0;
    case (state_r)
      S_CLEAR: begin
        clr_nxt    = clr_r + 1'b1;
        last_we    = 1'b1;
        last_waddr = clr_r;
        last_wdata = '0;
        hc_we      = 1'b1;
        hc_waddr   = clr_r;
        hc_wdata   = '0;
      end
      S_IDLE: begin
        if (in_acc) begin
          slot_nxt    = in_slot_idx;
          now_nxt     = in_now;
          base_nxt    = WIN_AW'(in_slot_idx * WINDOW_DEPTH);
          verdict_nxt = early_verdict;
        end
      end
      S_LAST: begin
        if (too_soon) begin
          verdict_nxt = V_SOON;
          last_we     = cfg.renew_delay;
        end else begin
          ptr_nxt  = hc_head;
          cnt_nxt  = hc_count;
          drop_nxt = '0;
        end
      end
      S_SCAN_CHK: begin
        if (age.gt_window) begin
          drop_nxt = drop_r + 1'b1;
          ptr_nxt  = ptr_inc;
        end
      end
      S_DECIDE: begin
        // expired entries go even when the request is refused
        hc_we = 1'b1;
        if (room) begin
          hc_wdata    = {ptr_r, remain + 1'b1};
          last_we     = 1'b1;
          win_we      = 1'b1;
          verdict_nxt = V_ACCEPT;
        end else begin
          verdict_nxt = V_RATE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_tvalid_nxt  = 1'b1;
          out_verdict_nxt = verdict_r;
          out_show_nxt    = (verdict_r == V_ACCEPT) || (verdict_r == V_BYPASS);
        end
      end
      default: begin
        clr_nxt = clr_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r        <= slot_nxt;
    now_r         <= now_nxt;
    base_r        <= base_nxt;
    ptr_r         <= ptr_nxt;
    cnt_r         <= cnt_nxt;
    drop_r        <= drop_nxt;
    verdict_r     <= verdict_nxt;
    out_verdict_r <= out_verdict_nxt;
    out_show_r    <= out_show_nxt;
  end

  // per-slot time of last accepted message
  psmrl_ram #(
    .WIDTH (TIME_W),
    .DEPTH (SLOTS)
  ) u_last_ram (
    .clk   (clk),
    .we    (last_we),
    .waddr (last_waddr),
    .wdata (last_wdata),
    .raddr (slot_raddr),
    .rdata (last_rdata)
  );

  // per-slot window head pointer and entry count
  psmrl_ram #(
    .WIDTH (HC_W),
    .DEPTH (SLOTS)
  ) u_hc_ram (
    .clk   (clk),
    .we    (hc_we),
    .waddr (hc_waddr),
    .wdata (hc_wdata),
    .raddr (slot_raddr),
    .rdata (hc_rdata)
  );

  // window timestamps, WINDOW_DEPTH entries per slot, only live ones read
  psmrl_ram #(
    .WIDTH (TIME_W),
    .DEPTH (WIN_ALL)
  ) u_win_ram (
    .clk   (clk),
    .we    (win_we),
    .waddr (win_waddr),
    .wdata (now_r),
    .raddr (win_raddr),
    .rdata (win_rdata)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'b0000, out_verdict_r, out_show_r};

endmodule

FILE: rtl/core/psmrl_ram.sv
// ----------------------------------------------------------------------------
// psmrl_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module psmrl_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/psmrl_age_unit.sv
// ----------------------------------------------------------------------------
// psmrl_age_unit
// shared age subtractor: now minus a stored stamp, modulo 2^32, and compares
// ----------------------------------------------------------------------------
module psmrl_age_unit
  import psmrl_pkg::*;
(
  input  logic [TIME_W-1:0] now,
  input  logic [TIME_W-1:0] stamp,
  input  logic [5:0]        min_delay,
  output age_flags_t        flags
);

  logic [TIME_W-1:0] age;

  assign age             = now - stamp;
  assign flags.lt_min    = age < {{(TIME_W-6){1'b0}}, min_delay};
  assign flags.gt_window = age > WINDOW_SECONDS;

endmodule

FILE: rtl/core/psmrl_cfg_regs.sv
// ----------------------------------------------------------------------------
// psmrl_cfg_regs
// configuration register file, written through the cfg channel
// ----------------------------------------------------------------------------
module psmrl_cfg_regs
  import psmrl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output cfg_t       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MAX_PER_MIN: begin
          cfg_nxt.max_per_minute = cfg_data[4:0];
        end
        CFG_BYPASS: begin
          cfg_nxt.bypass_level = cfg_data[6:0];
        end
        CFG_MIN_DELAY: begin
          cfg_nxt.min_delay = cfg_data[5:0];
        end
        CFG_RENEW: begin
          cfg_nxt.renew_delay = cfg_data[0];
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_per_minute <= MAX_PER_MIN_RST;
      cfg_r.bypass_level   <= BYPASS_RST;
      cfg_r.min_delay      <= MIN_DELAY_RST;
      cfg_r.renew_delay    <= RENEW_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/core/psmrl_checker.sv
// ----------------------------------------------------------------------------
// psmrl_checker
// port-level checks on the rate limiter, bound to the top level
// ----------------------------------------------------------------------------
`include "per_slot_message_rate_limiter_defines.svh"

module psmrl_checker
  import psmrl_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // result held while the receiver stalls
  `PSMRL_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  `PSMRL_ASSERT_NXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata))

  // only defined verdict codes leave the block
  `PSMRL_ASSERT_IMP(a_verdict_code, out_tvalid, out_tdata[3:1] <= V_RATE)

  // shown exactly when accepted or bypassed
  `PSMRL_ASSERT_IMP(a_show_match, out_tvalid,
    out_tdata[0] == ((out_tdata[3:1] == V_ACCEPT) || (out_tdata[3:1] == V_BYPASS)))

  // one request at a time
  `PSMRL_ASSERT_NXT(a_one_in_flight, in_tvalid && in_tready, !in_tready)

endmodule

bind per_slot_message_rate_limiter psmrl_checker u_psmrl_checker (.*);
